// File: rtl/core/dss_pkg.sv
`timescale 1ns / 1ps
package dss_pkg;

  localparam int MAX_REQUESTS_DEF = 32;
  localparam int TRACK_BITS_DEF   = 16;

  // positions and max_track keep at most this many low bits
  localparam int POS_KEEP_W = 16;

  localparam int SEEK_W    = 24;
  localparam int CNT_OUT_W = 6;
  localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

  localparam logic [POS_KEEP_W-1:0] MAX_TRACK_RST = 16'hFFFF;

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POLICY_MODE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_TRACK   = 1'b1;

  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd5;

  typedef enum logic [1:0] {
    SEL_MIN_HI,
    SEL_MAX_LO,
    SEL_MIN_LO,
    SEL_NEAR
  } sel_kind_t;

  typedef struct packed {
    logic      clr;
    logic      feed;
    sel_kind_t kind;
  } sel_ctrl_t;

endpackage

// File: rtl/core/dss_select.sv
`timescale 1ns / 1ps
module dss_select #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = dss_pkg::TRACK_BITS_DEF,
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dss_pkg::sel_ctrl_t    ctrl,
  input  logic [TRACK_BITS-1:0] pivot,
  input  logic [TRACK_BITS-1:0] head,
  input  logic [TRACK_BITS-1:0] val,
  input  logic [IDX_W-1:0]      idx,
  output logic                  found,
  output logic [TRACK_BITS-1:0] best_val,
  output logic [IDX_W-1:0]      best_idx
);

  logic                  found_r;
  logic [TRACK_BITS-1:0] best_val_r;
  logic [TRACK_BITS-1:0] best_gap_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [TRACK_BITS-1:0] gap;
  logic                  at_or_above;
  logic                  cand;
  logic                  better;

  assign gap         = (val >= head) ? (val - head) : (head - val);
  assign at_or_above = (val >= pivot);

  always_comb begin
    unique case (ctrl.kind)
      dss_pkg::SEL_MIN_HI: begin
        cand   = at_or_above;
        better = val < best_val_r;
      end
      dss_pkg::SEL_MAX_LO: begin
        cand   = !at_or_above;
        better = val > best_val_r;
      end
      dss_pkg::SEL_MIN_LO: begin
        cand   = !at_or_above;
        better = val < best_val_r;
      end
      default: begin
        // ties go to the later entry
        cand   = 1'b1;
        better = gap <= best_gap_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctrl.clr) begin
      found_r <= 1'b0;
    end else if (ctrl.feed && cand && (!found_r || better)) begin
      found_r    <= 1'b1;
      best_val_r <= val;
      best_gap_r <= gap;
      best_idx_r <= idx;
    end
  end

  assign found    = found_r;
  assign best_val = best_val_r;
  assign best_idx = best_idx_r;

endmodule

// File: rtl/core/dss_move.sv
`timescale 1ns / 1ps
module dss_move #(
  parameter int TRACK_BITS = dss_pkg::TRACK_BITS_DEF
) (
  input  logic [TRACK_BITS-1:0]      head,
  input  logic [TRACK_BITS-1:0]      target,
  input  logic [dss_pkg::SEEK_W-1:0] sum,
  output logic [TRACK_BITS-1:0]      span,
  output logic [dss_pkg::SEEK_W-1:0] sum_nxt
);

  localparam int ACC_W =
    ((TRACK_BITS > dss_pkg::SEEK_W) ? TRACK_BITS : dss_pkg::SEEK_W) + 1;

  logic [ACC_W-1:0] acc;

  assign span = (target >= head) ? (target - head) : (head - target);
  assign acc  = ACC_W'(sum) + ACC_W'(span);

  // saturating running seek
  assign sum_nxt = (acc > ACC_W'(dss_pkg::SEEK_MAX)) ? dss_pkg::SEEK_MAX
                                                     : acc[dss_pkg::SEEK_W-1:0];

endmodule

// File: rtl/core/disk_seek_scheduler_top.sv
`timescale 1ns / 1ps
// start and request items: each transfer is taken whenever the block is idle
// last item: n stored requests are served through one compare unit that scans the
// request memory one entry per cycle for every selected move (sstf and the scan
// family), plus a pass per finished sweep; fcfs reads the entries one by one in order
// without a scan; stalls on the result side hold the block until the result is taken
// reset (rst_n low, synchronous): empty batch, start 0, mode fcfs, max_track all ones in its kept low bits
module disk_seek_scheduler_top #(
  parameter int MAX_REQUESTS = dss_pkg::MAX_REQUESTS_DEF,
  parameter int TRACK_BITS   = dss_pkg::TRACK_BITS_DEF,
  localparam int IN_DATA_W   = ((TRACK_BITS + 7) / 8) * 8,
  localparam int OUT_RAW_W   = 3 * TRACK_BITS + dss_pkg::SEEK_W + dss_pkg::CNT_OUT_W + 2,
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [IN_DATA_W-1:0]           in_tdata,   // track_pos
  input  logic                           in_tuser,   // is_start
  input  logic                           in_tlast,   // is_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // from_pos, to_pos, move_dist, seek_total, req_count, range_error, overflow
  output logic [OUT_DATA_W-1:0]          out_tdata,
  output logic                           out_tuser,  // is_summary
  output logic                           out_tlast,  // last
  input  logic                           cfg_we,
  input  logic [dss_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TRACK_BITS-1:0]          cfg_wdata
);

  localparam int IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int KEEP_W = (TRACK_BITS < dss_pkg::POS_KEEP_W) ? TRACK_BITS
                                                             : dss_pkg::POS_KEEP_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ENTER,
    ST_FCFS_RD,
    ST_FCFS_WAIT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_MOVE,
    ST_SUMMARY
  } state_t;

  typedef enum logic [2:0] {
    PH_FCFS,
    PH_NEAR,
    PH_UP_HI,
    PH_TOP,
    PH_ZERO,
    PH_DOWN_LO,
    PH_UP_LO,
    PH_SUM
  } phase_t;

  function automatic phase_t first_phase(logic [dss_pkg::MODE_W-1:0] m);
    phase_t ph;
    unique case (m)
      dss_pkg::MODE_SSTF:  ph = PH_NEAR;
      dss_pkg::MODE_SCAN,
      dss_pkg::MODE_CSCAN,
      dss_pkg::MODE_LOOK,
      dss_pkg::MODE_CLOOK: ph = PH_UP_HI;
      default:             ph = PH_FCFS;
    endcase
    return ph;
  endfunction

  function automatic phase_t next_phase(logic [dss_pkg::MODE_W-1:0] m, phase_t cur);
    phase_t ph;
    unique case (cur)
      PH_UP_HI: begin
        if (m == dss_pkg::MODE_SCAN || m == dss_pkg::MODE_CSCAN) ph = PH_TOP;
        else if (m == dss_pkg::MODE_LOOK) ph = PH_DOWN_LO;
        else ph = PH_UP_LO;
      end
      PH_TOP:     ph = (m == dss_pkg::MODE_SCAN) ? PH_DOWN_LO : PH_ZERO;
      PH_ZERO:    ph = (m == dss_pkg::MODE_CSCAN) ? PH_UP_LO : PH_SUM;
      PH_DOWN_LO: ph = (m == dss_pkg::MODE_SCAN) ? PH_ZERO : PH_SUM;
      default:    ph = PH_SUM;
    endcase
    return ph;
  endfunction

  state_t                      state_r;
  phase_t                      phase_r;
  logic [dss_pkg::MODE_W-1:0]  policy_r;
  logic [TRACK_BITS-1:0]       max_track_r;
  logic [CNT_W-1:0]            count_r;
  logic [TRACK_BITS-1:0]       start_pos_r;
  logic [TRACK_BITS-1:0]       head_r;
  logic [TRACK_BITS-1:0]       target_r;
  logic [dss_pkg::SEEK_W-1:0]  sum_r;
  logic                        range_err_r;
  logic                        ovf_r;
  logic [MAX_REQUESTS-1:0]     served_r;
  logic [CNT_W-1:0]            scan_idx_r;
  logic                        rd_vld_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic [TRACK_BITS-1:0]       rd_data_r;
  logic                        out_valid_r;
  logic [OUT_DATA_W-1:0]       out_data_r;
  logic                        out_last_r;

  logic [TRACK_BITS-1:0]       mem [MAX_REQUESTS];

  logic [TRACK_BITS-1:0]       pos;
  logic                        in_fire;
  logic                        pos_over;
  logic                        full;
  logic                        wr_en;
  logic                        rd_en;
  logic                        out_free;
  logic                        out_emit;
  logic                        scan_end;
  dss_pkg::sel_ctrl_t          sel_ctrl;
  logic                        sel_found;
  logic [TRACK_BITS-1:0]       sel_val;
  logic [IDX_W-1:0]            sel_idx;
  logic [TRACK_BITS-1:0]       mv_dist;
  logic [dss_pkg::SEEK_W-1:0]  mv_sum;

  assign pos       = TRACK_BITS'(in_tdata[KEEP_W-1:0]);
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign pos_over  = pos > max_track_r;
  assign full      = count_r >= CNT_W'(MAX_REQUESTS);
  assign wr_en     = in_fire && !in_tuser && !pos_over && !full;
  assign rd_en     = (state_r == ST_SCAN) ||
                     ((state_r == ST_FCFS_RD) && (scan_idx_r < count_r));
  assign out_free  = !out_valid_r || out_tready;
  assign out_emit  = out_free && ((state_r == ST_MOVE) || (state_r == ST_SUMMARY));
  assign scan_end  = ({1'b0, scan_idx_r} + (CNT_W + 1)'(1)) >= {1'b0, count_r};

  always_comb begin
    sel_ctrl.clr  = (state_r == ST_SCAN) && (scan_idx_r == '0);
    sel_ctrl.feed = rd_vld_r && !served_r[rd_idx_r];
    unique case (phase_r)
      PH_UP_HI:   sel_ctrl.kind = dss_pkg::SEL_MIN_HI;
      PH_DOWN_LO: sel_ctrl.kind = dss_pkg::SEL_MAX_LO;
      PH_UP_LO:   sel_ctrl.kind = dss_pkg::SEL_MIN_LO;
      default:    sel_ctrl.kind = dss_pkg::SEL_NEAR;
    endcase
  end

  dss_select #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (sel_ctrl),
    .pivot    (start_pos_r),
    .head     (head_r),
    .val      (rd_data_r),
    .idx      (rd_idx_r),
    .found    (sel_found),
    .best_val (sel_val),
    .best_idx (sel_idx)
  );

  dss_move #(
    .TRACK_BITS (TRACK_BITS)
  ) u_move (
    .head    (head_r),
    .target  (target_r),
    .sum     (sum_r),
    .span    (mv_dist),
    .sum_nxt (mv_sum)
  );

  // request memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= pos;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FCFS;
      policy_r    <= dss_pkg::MODE_FCFS;
      max_track_r <= TRACK_BITS'(dss_pkg::MAX_TRACK_RST);
      count_r     <= '0;
      start_pos_r <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      range_err_r <= 1'b0;
      ovf_r       <= 1'b0;
      served_r    <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          dss_pkg::CFG_POLICY_MODE: policy_r <= cfg_wdata[dss_pkg::MODE_W-1:0];
          default:                  max_track_r <= TRACK_BITS'(cfg_wdata[KEEP_W-1:0]);
        endcase
      end

      rd_vld_r <= (state_r == ST_SCAN) && (scan_idx_r < count_r);
      rd_idx_r <= scan_idx_r[IDX_W-1:0];

      if (out_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_tuser) begin
              count_r     <= '0;
              sum_r       <= '0;
              served_r    <= '0;
              ovf_r       <= 1'b0;
              range_err_r <= pos_over;
              start_pos_r <= pos_over ? max_track_r : pos;
              head_r      <= pos_over ? max_track_r : pos;
            end else if (pos_over) begin
              range_err_r <= 1'b1;
            end else if (full) begin
              ovf_r <= 1'b1;
            end else begin
              count_r <= count_r + CNT_W'(1);
            end
            if (in_tlast) begin
              state_r <= ST_START;
            end
          end
        end
        ST_START: begin
          head_r   <= start_pos_r;
          sum_r    <= '0;
          served_r <= '0;
          phase_r  <= first_phase(policy_r);
          state_r  <= ST_ENTER;
        end
        ST_ENTER: begin
          unique case (phase_r)
            PH_FCFS: begin
              scan_idx_r <= '0;
              state_r    <= ST_FCFS_RD;
            end
            PH_TOP: begin
              target_r <= max_track_r;
              state_r  <= ST_MOVE;
            end
            PH_ZERO: begin
              target_r <= '0;
              state_r  <= ST_MOVE;
            end
            PH_SUM: begin
              state_r <= ST_SUMMARY;
            end
            default: begin
              scan_idx_r <= '0;
              state_r    <= ST_SCAN;
            end
          endcase
        end
        ST_FCFS_RD: begin
          if (scan_idx_r >= count_r) begin
            phase_r <= PH_SUM;
            state_r <= ST_ENTER;
          end else begin
            state_r <= ST_FCFS_WAIT;
          end
        end
        ST_FCFS_WAIT: begin
          target_r <= rd_data_r;
          state_r  <= ST_MOVE;
        end
        ST_SCAN: begin
          if (scan_end) begin
            state_r <= ST_DRAIN;
          end else begin
            scan_idx_r <= scan_idx_r + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (sel_found) begin
            target_r          <= sel_val;
            served_r[sel_idx] <= 1'b1;
            state_r           <= ST_MOVE;
          end else begin
            phase_r <= next_phase(policy_r, phase_r);
            state_r <= ST_ENTER;
          end
        end
        ST_MOVE: begin
          if (out_free) begin
            out_last_r  <= 1'b0;
            out_data_r  <= OUT_DATA_W'({ovf_r, range_err_r,
                                        dss_pkg::CNT_OUT_W'(count_r),
                                        mv_sum, mv_dist, target_r, head_r});
            head_r      <= target_r;
            sum_r       <= mv_sum;
            unique case (phase_r)
              PH_FCFS: begin
                scan_idx_r <= scan_idx_r + CNT_W'(1);
                state_r    <= ST_FCFS_RD;
              end
              PH_TOP, PH_ZERO: begin
                phase_r <= next_phase(policy_r, phase_r);
                state_r <= ST_ENTER;
              end
              default: begin
                scan_idx_r <= '0;
                state_r    <= ST_SCAN;
              end
            endcase
          end
        end
        ST_SUMMARY: begin
          if (out_free) begin
            out_last_r  <= 1'b1;
            out_data_r  <= OUT_DATA_W'({ovf_r, range_err_r,
                                        dss_pkg::CNT_OUT_W'(count_r),
                                        sum_r, TRACK_BITS'(0), head_r, start_pos_r});
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_last_r;
  assign out_tlast  = out_last_r;

endmodule
